// File: rtl/wpl_pkg.sv
package wpl_pkg;

  localparam int unsigned WHEELS_DEF = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BONUS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_K   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_K  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_K  = 3'd6;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WHEEL = 1'b1;

  localparam logic KIND_POWER  = 1'b0;
  localparam logic KIND_TORQUE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] motion_torque;
    logic signed [31:0] balance_torque;
    logic signed [31:0] wheel_speed;
    logic [30:0]        referee_power;
    logic [30:0]        energy_measured;
    logic [30:0]        energy_goal;
  } wpl_in_t;

  typedef struct packed {
    logic               result_kind;
    logic               wheel_number;
    logic signed [31:0] torque_out;
    logic [30:0]        power_limit;
    logic signed [31:0] demanded_power;
    logic signed [31:0] granted_power;
    logic               limited;
    logic               last_of_run;
  } wpl_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TICK_P,
    ST_TICK_D,
    ST_TICK_END,
    ST_CMD,
    ST_PCMD,
    ST_DEMAND,
    ST_LIMIT,
    ST_PRED0,
    ST_PRED1,
    ST_PRED2,
    ST_PRED3,
    ST_PRED4,
    ST_ALLOC_MUL,
    ST_ALLOC_DIV,
    ST_ALLOC_SET,
    ST_BAL,
    ST_BAL_CHK,
    ST_SOLVE,
    ST_DISC0,
    ST_DISC1,
    ST_SQRT,
    ST_ROOT1,
    ST_ROOT2,
    ST_PICK,
    ST_VERT,
    ST_LIN,
    ST_POST,
    ST_GRANT,
    ST_DIV,
    ST_EMIT
  } wpl_state_e;

endpackage

// File: rtl/wheel_power_limiter_core.sv
// Wheel power limiter. An energy tick (opcode 0) runs the PD loop on the buffer energy error
// and returns one power limit word. Wheel commands (opcode 1) are taken one per cycle while
// the block is idle, in wheel order; the last wheel of a set starts the computation and the
// block then returns one torque word per wheel. All arithmetic runs through one 33x33
// multiplier, one radix-2 divider and one bit-pair square root, driven by the sequencer,
// so the input side stalls while a set is in work: shortest when the demand stays under
// the limit, and longest when every
// wheel needs the full quadratic solve (allocation divide, square root and up to three root
// divides per wheel). Output stalls lengthen the stall further.
// A finished word waits in the output register while the next item is taken.
module wheel_power_limiter_core
  import wpl_pkg::*;
#(
  parameter int unsigned WHEELS = WHEELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  wpl_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wpl_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic signed [31:0] S32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN    = -32'sh7FFF_FFFF - 32'sd1;
  localparam int unsigned        DIV_STEPS  = 64;
  localparam int unsigned        SQRT_STEPS = 32;

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'(S32_MAX)) r = S32_MAX;
    else if (v < 66'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'(S32_MAX)) r = S32_MAX;
    else if (v < 35'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic opp(input logic signed [33:0] a, input logic signed [33:0] b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

  // control
  wpl_state_e state_q, state_d, ret_q, ret_d;
  logic       wl_q, wi_q;
  logic       out_valid_q;
  wpl_out_t   out_q;

  // configuration and loop state
  logic signed [31:0] gain_p_q, gain_d_q;
  logic [30:0]        floor_q, bonus_q;
  logic [63:0]        k1_q, k2_q, k3_q;
  logic [30:0]        mp_q;
  logic signed [31:0] prev_err_q;

  // datapath
  logic [30:0]        ref_q, meas_q, goal_q;
  logic signed [31:0] mot_q [WHEELS];
  logic signed [31:0] bal_q [WHEELS];
  logic signed [31:0] spd_q [WHEELS];
  logic signed [31:0] tcmd_q [WHEELS];
  logic signed [31:0] pcmd_q [WHEELS];
  logic signed [31:0] tout_q [WHEELS];
  logic signed [65:0] prod_q;
  logic signed [49:0] pd_q;
  logic signed [31:0] pt_q, sq_q, st_q, pred_q;
  logic signed [34:0] acc_q, dem_acc_q, gr_acc_q;
  logic signed [31:0] demand_q, granted_q, alloc_q, c_q, x_q, x1_q;
  logic               limited_q, d_zero_q;
  logic signed [63:0] ww_q;
  logic [63:0]        sh_q;
  logic [34:0]        rem_q;
  logic [31:0]        dmag_q, root_q;
  logic               div_neg_q;
  logic [5:0]         cnt_q;

  logic in_acc, out_free, wl_last, wi_last;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign wl_last     = (2'(wl_q) == 2'(WHEELS - 1));
  assign wi_last     = (2'(wi_q) == 2'(WHEELS - 1));
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // per-wheel operands
  logic signed [31:0] w_cur, bal_cur, mot_cur, tcmd_cur, k1_c, k2_c, k3_c, k3s;
  logic signed [32:0] absw;
  assign w_cur    = spd_q[wi_q];
  assign bal_cur  = bal_q[wi_q];
  assign mot_cur  = mot_q[wi_q];
  assign tcmd_cur = tcmd_q[wi_q];
  assign k1_c     = $signed(wi_q ? k1_q[63:32] : k1_q[31:0]);
  assign k2_c     = $signed(wi_q ? k2_q[63:32] : k2_q[31:0]);
  assign k3_c     = $signed(wi_q ? k3_q[63:32] : k3_q[31:0]);
  assign k3s      = k3_c >>> 8;
  assign absw     = w_cur[31] ? -33'(w_cur) : 33'(w_cur);

  logic signed [31:0] fix16, fix24;
  assign fix16 = sat66(prod_q >>> 16);
  assign fix24 = sat66(prod_q >>> 24);

  // energy loop
  logic signed [31:0] err;
  logic signed [32:0] delta;
  logic signed [49:0] tk_pd, tk_mp, tk_lo;
  logic [31:0]        tk_sum;
  logic [30:0]        tk_hi, tk_lim;
  always_comb begin
    err    = $signed({1'b0, goal_q}) - $signed({1'b0, meas_q});
    delta  = 33'(err) - 33'(prev_err_q);
    tk_pd  = pd_q + $signed(prod_q[65:16]);
    tk_mp  = $signed(50'(ref_q)) - tk_pd;
    tk_lo  = (tk_mp < $signed(50'(floor_q))) ? $signed(50'(floor_q)) : tk_mp;
    tk_sum = 32'(ref_q) + 32'(bonus_q);
    tk_hi  = tk_sum[31] ? '1 : tk_sum[30:0];
    tk_lim = (tk_lo > $signed(50'(tk_hi))) ? tk_hi : tk_lo[30:0];
  end

  // set-level values
  logic signed [31:0] dem_sat, pred_next, c_d, div_res, x_lin, x_vert, x_pick, t_post;
  logic signed [63:0] disc;
  logic               lim, v1, v2, solve_lin, a_zero;
  logic signed [32:0] ax1, ax2;
  always_comb begin
    dem_sat   = sat35(dem_acc_q);
    lim       = $signed(33'(dem_sat)) > $signed(33'(mp_q));
    pred_next = sat35(acc_q + 35'(fix24) + 35'(k3s));
    c_d       = sat35(35'(st_q) + 35'(k3s) - 35'(alloc_q));
    a_zero    = (k2_c == 0);
    solve_lin = a_zero && (w_cur != 0);
    disc      = ww_q - (64'($signed(prod_q[65:8])) <<< 2);
    if (div_neg_q) div_res = (sh_q > 64'h8000_0000) ? S32_MIN : $signed(-sh_q[31:0]);
    else div_res = (sh_q > 64'h7FFF_FFFF) ? S32_MAX : $signed(sh_q[31:0]);
    x_lin  = opp(34'(div_res), 34'(tcmd_cur)) ? '0 : div_res;
    x_vert = (d_zero_q && opp(34'(div_res), 34'(tcmd_cur))) ? '0 : div_res;
    v1     = !opp(34'(x1_q), 34'(tcmd_cur));
    v2     = !opp(34'(div_res), 34'(tcmd_cur));
    ax1    = x1_q[31] ? -33'(x1_q) : 33'(x1_q);
    ax2    = div_res[31] ? -33'(div_res) : 33'(div_res);
    if (v1 && v2) x_pick = (ax1 >= ax2) ? x1_q : div_res;
    else if (v1) x_pick = x1_q;
    else x_pick = div_res;
    t_post = opp(34'(x_q) - 34'(bal_cur), 34'(mot_cur)) ? bal_cur : x_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OP_TICK) state_d = ST_TICK_P;
          else if (wl_last) state_d = ST_CMD;
        end
      end
      ST_TICK_P:   state_d = ST_TICK_D;
      ST_TICK_D:   state_d = ST_TICK_END;
      ST_TICK_END: if (out_free) state_d = ST_IDLE;
      ST_CMD:      state_d = ST_PCMD;
      ST_PCMD: begin
        state_d = ST_PRED0;
        ret_d   = ST_DEMAND;
      end
      ST_PRED0: state_d = ST_PRED1;
      ST_PRED1: state_d = ST_PRED2;
      ST_PRED2: state_d = ST_PRED3;
      ST_PRED3: state_d = ST_PRED4;
      ST_PRED4: state_d = ret_q;
      ST_DEMAND: state_d = wi_last ? ST_LIMIT : ST_PCMD;
      ST_LIMIT:  state_d = lim ? ST_ALLOC_MUL : ST_EMIT;
      ST_ALLOC_MUL: state_d = (demand_q > 0) ? ST_ALLOC_DIV : ST_BAL;
      ST_ALLOC_DIV: begin
        state_d = ST_DIV;
        ret_d   = ST_ALLOC_SET;
      end
      ST_ALLOC_SET: state_d = ST_BAL;
      ST_BAL: begin
        state_d = ST_PRED0;
        ret_d   = ST_BAL_CHK;
      end
      ST_BAL_CHK: state_d = (alloc_q <= pred_q) ? ST_POST : ST_SOLVE;
      ST_SOLVE: begin
        if (!a_zero) state_d = ST_DISC0;
        else if (solve_lin) begin
          state_d = ST_DIV;
          ret_d   = ST_LIN;
        end else state_d = ST_POST;
      end
      ST_DISC0: state_d = ST_DISC1;
      ST_DISC1: begin
        if (disc <= 0) begin
          state_d = ST_DIV;
          ret_d   = ST_VERT;
        end else state_d = ST_SQRT;
      end
      ST_SQRT: if (cnt_q == 6'(SQRT_STEPS - 1)) state_d = ST_ROOT1;
      ST_ROOT1: begin
        state_d = ST_DIV;
        ret_d   = ST_ROOT2;
      end
      ST_ROOT2: begin
        state_d = ST_DIV;
        ret_d   = ST_PICK;
      end
      ST_PICK: begin
        if (v1 || v2) state_d = ST_POST;
        else begin
          state_d = ST_DIV;
          ret_d   = ST_VERT;
        end
      end
      ST_VERT: state_d = ST_POST;
      ST_LIN:  state_d = ST_POST;
      ST_POST: begin
        state_d = ST_PRED0;
        ret_d   = ST_GRANT;
      end
      ST_GRANT: state_d = wi_last ? ST_EMIT : ST_ALLOC_MUL;
      ST_DIV:   if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ret_q;
      ST_EMIT:  if (out_free && wi_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // unit controls and result word
  logic               mul_en, div_go, sqrt_go, out_load;
  logic signed [32:0] mul_a, mul_b;
  logic signed [63:0] div_num;
  logic signed [31:0] div_den;
  wpl_out_t           out_next;
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    div_go   = 1'b0;
    div_num  = '0;
    div_den  = '0;
    sqrt_go  = 1'b0;
    out_load = 1'b0;
    out_next = '0;
    case (state_q)
      ST_TICK_P: begin
        mul_en = 1'b1;
        mul_a  = 33'(err);
        mul_b  = 33'(gain_p_q);
      end
      ST_TICK_D: begin
        mul_en = 1'b1;
        mul_a  = delta;
        mul_b  = 33'(gain_d_q);
      end
      ST_TICK_END: begin
        out_load             = out_free;
        out_next.result_kind = KIND_POWER;
        out_next.power_limit = tk_lim;
        out_next.last_of_run = 1'b1;
      end
      ST_PRED0: begin
        mul_en = 1'b1;
        mul_a  = 33'(pt_q);
        mul_b  = 33'(pt_q);
      end
      ST_PRED1: begin
        mul_en = 1'b1;
        mul_a  = 33'(pt_q);
        mul_b  = 33'(w_cur);
      end
      ST_PRED2: begin
        mul_en = 1'b1;
        mul_a  = 33'(k1_c);
        mul_b  = absw;
      end
      ST_PRED3: begin
        mul_en = 1'b1;
        mul_a  = 33'(k2_c);
        mul_b  = 33'(sq_q);
      end
      ST_ALLOC_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed(33'(mp_q));
        mul_b  = 33'(pcmd_q[wi_q]);
      end
      ST_ALLOC_DIV: begin
        div_go  = 1'b1;
        div_num = prod_q[63:0];
        div_den = demand_q;
      end
      ST_SOLVE: begin
        mul_en  = !a_zero;
        mul_a   = 33'(w_cur);
        mul_b   = 33'(w_cur);
        div_go  = solve_lin;
        div_num = -(64'(c_d) <<< 16);
        div_den = w_cur;
      end
      ST_DISC0: begin
        mul_en = 1'b1;
        mul_a  = 33'(k2_c);
        mul_b  = 33'(c_q);
      end
      ST_DISC1: begin
        div_go  = (disc <= 0);
        sqrt_go = (disc > 0);
        div_num = -(64'(w_cur) <<< 23);
        div_den = k2_c;
      end
      ST_ROOT1: begin
        div_go  = 1'b1;
        div_num = ($signed(64'(root_q)) - 64'(w_cur)) <<< 23;
        div_den = k2_c;
      end
      ST_ROOT2: begin
        div_go  = 1'b1;
        div_num = (-$signed(64'(root_q)) - 64'(w_cur)) <<< 23;
        div_den = k2_c;
      end
      ST_PICK: begin
        div_go  = !(v1 || v2);
        div_num = -(64'(w_cur) <<< 23);
        div_den = k2_c;
      end
      ST_EMIT: begin
        out_load                = out_free;
        out_next.result_kind    = KIND_TORQUE;
        out_next.wheel_number   = wi_q;
        out_next.torque_out     = tout_q[wi_q];
        out_next.power_limit    = mp_q;
        out_next.demanded_power = demand_q;
        out_next.granted_power  = granted_q;
        out_next.limited        = limited_q;
        out_next.last_of_run    = wi_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      wl_q        <= 1'b0;
      wi_q        <= 1'b0;
      out_valid_q <= 1'b0;
      gain_p_q    <= '0;
      gain_d_q    <= '0;
      floor_q     <= '0;
      bonus_q     <= '0;
      k1_q        <= '0;
      k2_q        <= '0;
      k3_q        <= '0;
      mp_q        <= '0;
      prev_err_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GAIN_P:   gain_p_q <= $signed(cfg_data_i[31:0]);
          CFG_GAIN_D:   gain_d_q <= $signed(cfg_data_i[31:0]);
          CFG_FLOOR:    floor_q  <= cfg_data_i[30:0];
          CFG_BONUS:    bonus_q  <= cfg_data_i[30:0];
          CFG_SPEED_K:  k1_q     <= cfg_data_i;
          CFG_TORQUE_K: k2_q     <= cfg_data_i;
          CFG_STATIC_K: k3_q     <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc && in_data_i.opcode == OP_WHEEL) wl_q <= wl_last ? 1'b0 : 1'b1;
      if (state_q == ST_TICK_END && out_free) begin
        mp_q       <= tk_lim;
        prev_err_q <= err;
      end
      case (state_q)
        ST_CMD, ST_LIMIT: wi_q <= 1'b0;
        ST_DEMAND, ST_GRANT: wi_q <= wi_last ? 1'b0 : 1'b1;
        ST_EMIT: if (out_free && !wi_last) wi_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_next;
    if (mul_en) prod_q <= mul_a * mul_b;
    if (in_acc) begin
      if (in_data_i.opcode == OP_TICK) begin
        ref_q  <= in_data_i.referee_power;
        meas_q <= in_data_i.energy_measured;
        goal_q <= in_data_i.energy_goal;
      end else begin
        mot_q[wl_q] <= in_data_i.motion_torque;
        bal_q[wl_q] <= in_data_i.balance_torque;
        spd_q[wl_q] <= in_data_i.wheel_speed;
      end
    end
    // divider and square root share the shift register and remainder
    if (div_go) begin
      div_neg_q <= div_num[63] ^ div_den[31];
      sh_q      <= div_num[63] ? 64'(-div_num) : 64'(div_num);
      dmag_q    <= div_den[31] ? 32'(-div_den) : 32'(div_den);
      rem_q     <= '0;
      cnt_q     <= '0;
    end
    if (sqrt_go) begin
      sh_q   <= 64'(disc);
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end
    case (state_q)
      ST_TICK_D: pd_q <= $signed(prod_q[65:16]);
      ST_CMD: begin
        for (int i = 0; i < WHEELS; i++) begin
          tcmd_q[i] <= sat35(35'(mot_q[i]) + 35'(bal_q[i]));
        end
        dem_acc_q <= '0;
      end
      ST_PCMD: pt_q <= tcmd_cur;
      ST_PRED1: sq_q <= fix16;
      ST_PRED2: acc_q <= 35'(fix16);
      ST_PRED3: begin
        st_q  <= fix24;
        acc_q <= acc_q + 35'(fix24);
      end
      ST_PRED4: pred_q <= pred_next;
      ST_DEMAND: begin
        pcmd_q[wi_q] <= pred_q;
        dem_acc_q    <= dem_acc_q + 35'(pred_q);
      end
      ST_LIMIT: begin
        demand_q  <= dem_sat;
        limited_q <= lim;
        gr_acc_q  <= '0;
        if (!lim) begin
          granted_q <= dem_sat;
          for (int i = 0; i < WHEELS; i++) begin
            tout_q[i] <= tcmd_q[i];
          end
        end
      end
      ST_ALLOC_MUL: if (!(demand_q > 0)) alloc_q <= $signed(32'(mp_q / WHEELS));
      ST_ALLOC_SET: alloc_q <= div_res;
      ST_BAL: pt_q <= bal_cur;
      ST_BAL_CHK: if (alloc_q <= pred_q) x_q <= bal_cur;
      ST_SOLVE: begin
        c_q <= c_d;
        if (a_zero && !solve_lin) x_q <= tcmd_cur;
      end
      ST_DISC0: ww_q <= prod_q[63:0];
      ST_DISC1: d_zero_q <= (disc == 0);
      ST_SQRT: begin : sqrt_step
        logic [34:0] rs, trial;
        logic        ge;
        rs     = {rem_q[32:0], sh_q[63:62]};
        trial  = {1'b0, root_q, 2'b01};
        ge     = (rs >= trial);
        rem_q  <= ge ? rs - trial : rs;
        root_q <= {root_q[30:0], ge};
        sh_q   <= {sh_q[61:0], 2'b00};
        cnt_q  <= cnt_q + 6'd1;
      end
      ST_DIV: begin : div_step
        logic [32:0] rs;
        logic        ge;
        rs    = {rem_q[31:0], sh_q[63]};
        ge    = (rs >= {1'b0, dmag_q});
        rem_q <= 35'(ge ? rs - {1'b0, dmag_q} : rs);
        sh_q  <= {sh_q[62:0], ge};
        cnt_q <= cnt_q + 6'd1;
      end
      ST_ROOT2: x1_q <= div_res;
      ST_PICK: if (v1 || v2) x_q <= x_pick;
      ST_VERT: x_q <= x_vert;
      ST_LIN:  x_q <= x_lin;
      ST_POST: begin
        tout_q[wi_q] <= t_post;
        pt_q         <= t_post;
      end
      ST_GRANT: begin
        gr_acc_q <= gr_acc_q + 35'(pred_q);
        if (wi_last) granted_q <= sat35(gr_acc_q + 35'(pred_q));
      end
      default: ;
    endcase
  end

endmodule

// File: tb/wpl_torque_checker.sv
module wpl_torque_checker
  import wpl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  wpl_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  wpl_out_t              out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    open_words_o,
  output int                    limited_sets_o
);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  longint gain_p, gain_d, floor_w, bonus_w;
  logic [63:0] k1_reg, k2_reg, k3_reg;
  longint limit_now, last_err;
  longint wl_motion [2];
  longint wl_bal [2];
  longint wl_speed [2];
  int unsigned loaded;
  wpl_out_t due_words [$];

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b, int n);
    return sat32((a * b) >>> n);
  endfunction

  function automatic longint fdiv(longint num, longint den);
    return sat32(num / den);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit opposed(longint a, longint b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

  function automatic longint slot(logic [63:0] r, int i);
    logic signed [31:0] s;
    s = r[32*i +: 32];
    return longint'(s);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint speed_loss(int i, longint w);
    return fmul(slot(k1_reg, i), mag(w), 24);
  endfunction

  function automatic longint wheel_power(int i, longint tau, longint w);
    longint sq;
    sq = fmul(tau, tau, 16);
    return sat32(fmul(tau, w, 16) + speed_loss(i, w) + fmul(slot(k2_reg, i), sq, 24)
                 + (slot(k3_reg, i) >>> 8));
  endfunction

  function automatic longint restricted_torque(int i, longint w, longint alloc, longint tcmd);
    longint a, c, d, vtx, s, x1, x2, x;
    bit ok1, ok2;
    a = slot(k2_reg, i);
    c = sat32(speed_loss(i, w) + (slot(k3_reg, i) >>> 8) - alloc);
    if (a == 0) begin
      if (w == 0) return tcmd;
      x = fdiv(-c * 65536, w);
      return opposed(x, tcmd) ? 0 : x;
    end
    d = w * w - 4 * ((a * c) >>> 8);
    vtx = fdiv(-w * 8388608, a);
    if (d < 0) return vtx;
    if (d == 0) return opposed(vtx, tcmd) ? 0 : vtx;
    s = longint'(int_sqrt(longint'(d)));
    x1 = fdiv((s - w) * 8388608, a);
    x2 = fdiv((-s - w) * 8388608, a);
    ok1 = !opposed(x1, tcmd);
    ok2 = !opposed(x2, tcmd);
    if (ok1 && ok2) return (mag(x1) >= mag(x2)) ? x1 : x2;
    if (ok1) return x1;
    if (ok2) return x2;
    return vtx;
  endfunction

  task automatic absorb_word(input wpl_in_t it);
    longint refp, err, pd, mp, upper, demand, granted;
    longint tcmd [2];
    longint pcmd [2];
    longint tout [2];
    longint alloc;
    bit lim;
    int idx;
    wpl_out_t o;
    if (it.opcode == OP_TICK) begin
      refp = longint'({1'b0, it.referee_power});
      err = longint'({1'b0, it.energy_goal}) - longint'({1'b0, it.energy_measured});
      pd = ((gain_p * err) >>> 16) + ((gain_d * (err - last_err)) >>> 16);
      mp = refp - pd;
      upper = refp + bonus_w;
      if (mp < floor_w) mp = floor_w;
      if (upper > S32_MAX) upper = S32_MAX;
      if (mp > upper) mp = upper;
      limit_now = mp;
      last_err = err;
      o = '0;
      o.result_kind = KIND_POWER;
      o.power_limit = limit_now[30:0];
      o.last_of_run = 1'b1;
      due_words.push_back(o);
      return;
    end
    idx = (loaded >= WHEELS_DEF) ? 0 : loaded;
    wl_motion[idx] = longint'(it.motion_torque);
    wl_bal[idx] = longint'(it.balance_torque);
    wl_speed[idx] = longint'(it.wheel_speed);
    loaded = idx + 1;
    if (loaded < WHEELS_DEF) return;
    loaded = 0;
    demand = 0;
    granted = 0;
    for (int i = 0; i < 2; i++) begin
      tcmd[i] = sat32(wl_motion[i] + wl_bal[i]);
      pcmd[i] = wheel_power(i, tcmd[i], wl_speed[i]);
      demand += pcmd[i];
    end
    demand = sat32(demand);
    lim = demand > limit_now;
    if (!lim) begin
      tout = tcmd;
      granted = demand;
    end else begin
      limited_sets_o++;
      for (int i = 0; i < 2; i++) begin
        alloc = (demand > 0) ? fdiv(limit_now * pcmd[i], demand) : limit_now / 2;
        if (alloc <= wheel_power(i, wl_bal[i], wl_speed[i])) begin
          tout[i] = wl_bal[i];
        end else begin
          tout[i] = restricted_torque(i, wl_speed[i], alloc, tcmd[i]);
          if (opposed(tout[i] - wl_bal[i], wl_motion[i])) tout[i] = wl_bal[i];
        end
        granted += wheel_power(i, tout[i], wl_speed[i]);
      end
      granted = sat32(granted);
    end
    for (int i = 0; i < 2; i++) begin
      o.result_kind = KIND_TORQUE;
      o.wheel_number = i[0];
      o.torque_out = tout[i][31:0];
      o.power_limit = limit_now[30:0];
      o.demanded_power = demand[31:0];
      o.granted_power = granted[31:0];
      o.limited = lim;
      o.last_of_run = (i == 1);
      due_words.push_back(o);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  task automatic compare_word(input wpl_out_t got);
    wpl_out_t w;
    if (due_words.size() == 0) begin
      report("unexpected word", longint'(got), 0);
      return;
    end
    w = due_words.pop_front();
    if (got.result_kind !== w.result_kind) report("result_kind", got.result_kind, w.result_kind);
    if (got.wheel_number !== w.wheel_number)
      report("wheel_number", got.wheel_number, w.wheel_number);
    if (got.torque_out !== w.torque_out) report("torque_out", got.torque_out, w.torque_out);
    if (got.power_limit !== w.power_limit) report("power_limit", got.power_limit, w.power_limit);
    if (got.demanded_power !== w.demanded_power)
      report("demanded_power", got.demanded_power, w.demanded_power);
    if (got.granted_power !== w.granted_power)
      report("granted_power", got.granted_power, w.granted_power);
    if (got.limited !== w.limited) report("limited", got.limited, w.limited);
    if (got.last_of_run !== w.last_of_run) report("last_of_run", got.last_of_run, w.last_of_run);
  endtask

  initial begin
    errors_o = 0;
    open_words_o = 0;
    limited_sets_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p = 0; gain_d = 0; floor_w = 0; bonus_w = 0;
      k1_reg = '0; k2_reg = '0; k3_reg = '0;
      limit_now = 0; last_err = 0; loaded = 0;
      for (int i = 0; i < 2; i++) begin
        wl_motion[i] = 0; wl_bal[i] = 0; wl_speed[i] = 0;
      end
      due_words.delete();
    end else begin
      // outputs first: a word accepted now cannot stem from this edge's input
      if (out_valid_i && !out_stall_i) compare_word(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GAIN_P:   gain_p = longint'($signed(cfg_data_i[31:0]));
          CFG_GAIN_D:   gain_d = longint'($signed(cfg_data_i[31:0]));
          CFG_FLOOR:    floor_w = longint'({33'd0, cfg_data_i[30:0]});
          CFG_BONUS:    bonus_w = longint'({33'd0, cfg_data_i[30:0]});
          CFG_SPEED_K:  k1_reg = cfg_data_i;
          CFG_TORQUE_K: k2_reg = cfg_data_i;
          CFG_STATIC_K: k3_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_word(in_data_i);
    end
    open_words_o = due_words.size();
  end

endmodule

// File: tb/tb_wheel_power_limiter_core.sv
module tb_wheel_power_limiter_core;
  import wpl_pkg::*;

  localparam int  ITEMS_PER_PHASE = 310;
  localparam int  PHASES          = 6;
  localparam int  SETTLE_CYCLES   = 700;
  localparam longint CYCLE_LIMIT  = 4000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  wpl_in_t               in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  wpl_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int     errors, open_words, limited_sets;
  bit     quiet = 1'b0;
  longint cycles = 0;
  int     words_sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  wheel_power_limiter_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  wpl_torque_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .open_words_o(open_words), .limited_sets_o(limited_sets)
  );

  always @(posedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 38);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_wheel_power_limiter_core: errors");
      $finish;
    end
  end

  task automatic push_word(input wpl_in_t it);
    if (!quiet && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!quiet && $urandom_range(99) < 38);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold until every expected word is back, then let a set still in work finish
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (open_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] around(int r);
    return 32'($signed($urandom_range(2 * r)) - r);
  endfunction

  function automatic logic [31:0] any32();
    return $urandom();
  endfunction

  function automatic wpl_in_t tick(logic [30:0] refp, logic [30:0] meas, logic [30:0] goal);
    wpl_in_t it;
    it = '0;
    it.opcode = OP_TICK;
    it.referee_power = refp;
    it.energy_measured = meas;
    it.energy_goal = goal;
    it.motion_torque = any32();
    it.wheel_speed = any32();
    return it;
  endfunction

  function automatic wpl_in_t wheel(logic [31:0] m, logic [31:0] b, logic [31:0] w);
    wpl_in_t it;
    it = '0;
    it.opcode = OP_WHEEL;
    it.motion_torque = m;
    it.balance_torque = b;
    it.wheel_speed = w;
    it.referee_power = 31'(any32());
    it.energy_goal = 31'(any32());
    return it;
  endfunction

  function automatic logic [63:0] coef_pair(int unsigned hi);
    return {32'($urandom_range(hi)), 32'($urandom_range(hi))};
  endfunction

  task automatic set_regs(input int mode);
    case (mode)
      0: begin
        write_reg(CFG_GAIN_P, 64'(around(65536)));
        write_reg(CFG_GAIN_D, 64'(around(32768)));
        write_reg(CFG_FLOOR, 64'(20 << 16));
        write_reg(CFG_BONUS, 64'(30 << 16));
        write_reg(CFG_SPEED_K, coef_pair(5000000));
        write_reg(CFG_TORQUE_K, coef_pair(8000000) | 64'h0000_0001_0000_0001);
        write_reg(CFG_STATIC_K, coef_pair(50000000));
      end
      1: begin
        // linear solve on both wheels
        write_reg(CFG_GAIN_P, 64'd0);
        write_reg(CFG_GAIN_D, 64'd0);
        write_reg(CFG_FLOOR, 64'($urandom_range(60 << 16)));
        write_reg(CFG_TORQUE_K, 64'd0);
        write_reg(CFG_STATIC_K, coef_pair(30000000));
      end
      2: begin
        write_reg(CFG_GAIN_P, 64'h8000_0000);
        write_reg(CFG_GAIN_D, 64'h7fff_ffff);
        write_reg(CFG_FLOOR, 64'h7fff_ffff);
        write_reg(CFG_BONUS, 64'h7fff_ffff);
        write_reg(CFG_SPEED_K, {64{1'b1}});
        write_reg(CFG_TORQUE_K, 64'h8000_0000_7fff_ffff);
        write_reg(CFG_STATIC_K, 64'h7fff_ffff_8000_0000);
      end
      3: begin
        write_reg(CFG_GAIN_P, 64'h7fff_ffff);
        write_reg(CFG_GAIN_D, 64'h8000_0000);
        write_reg(CFG_FLOOR, 64'd0);
        write_reg(CFG_BONUS, 64'd0);
        write_reg(CFG_SPEED_K, 64'd0);
        write_reg(CFG_TORQUE_K, coef_pair(8000000));
        write_reg(CFG_STATIC_K, 64'd0);
      end
      default: begin
        write_reg(CFG_GAIN_P, {$urandom(), $urandom()});
        write_reg(CFG_GAIN_D, 64'(around(131072)));
        write_reg(CFG_FLOOR, {$urandom(), $urandom()});
        write_reg(CFG_BONUS, 64'($urandom_range(100 << 16)));
        write_reg(CFG_SPEED_K, {$urandom(), $urandom()});
        write_reg(CFG_TORQUE_K, coef_pair(16000000));
        write_reg(CFG_STATIC_K, {$urandom(), $urandom()});
      end
    endcase
  endtask

  task automatic random_word;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      // noise: whole field ranges
      if ($urandom_range(1)) push_word(tick(31'(any32()), 31'(any32()), 31'(any32())));
      else push_word(wheel(any32(), any32(), any32()));
    end else if (pick < 30) begin
      push_word(tick(31'($urandom_range(40 << 16, 120 << 16)), 31'($urandom_range(60 << 16)),
                     31'($urandom_range(60 << 16))));
    end else if (pick < 36) begin
      // stationary wheel
      push_word(wheel(around(3 << 16), around(1 << 15), 32'd0));
    end else begin
      push_word(wheel(around(3 << 16), around(1 << 16), around(60 << 16)));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_regs(0);
    quiet = 1'b1;
    push_word(tick(31'h7fff_ffff, 31'd0, 31'h7fff_ffff));
    push_word(tick(31'd0, 31'h7fff_ffff, 31'd0));
    push_word(tick(31'(80 << 16), 31'(30 << 16), 31'(40 << 16)));
    push_word(wheel(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    push_word(wheel(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    push_word(wheel(32'(2 << 16), 32'(1 << 14), 32'(40 << 16)));
    // tick in the middle of a set
    push_word(tick(31'(60 << 16), 31'(10 << 16), 31'(20 << 16)));
    push_word(wheel(32'(-3 << 16), 32'(-1 << 14), 32'(-50 << 16)));
    // balance only, opposite to motion
    push_word(wheel(32'(3 << 16), 32'(-3 << 16), 32'(50 << 16)));
    push_word(wheel(32'(-3 << 16), 32'(3 << 16), 32'(-50 << 16)));
    push_word(wheel(32'd0, 32'd0, 32'd0));
    push_word(wheel(32'(3 << 16), 32'd0, 32'd0));
    quiet = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_regs(p == 0 ? 1 : p);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == 0) quiet = 1'b1;
        if (p == 2 && n == 150) quiet = 1'b0;
        if (p == 1 && n == 100) begin
          in_valid_i <= 1'b0;
          do @(negedge clk_i); while (open_words != 0);
          @(posedge clk_i);
        end
        if (p == 1 && n < 6) begin
          push_word(wheel(around(3 << 16), around(1 << 16), 32'd0));
        end else begin
          random_word();
        end
      end
    end
    drain();
    $display("%0d input words, %0d register settings, %0d sets over the power limit",
             words_sent, PHASES + 1, limited_sets);
    if (errors == 0) begin
      $display("tb_wheel_power_limiter_core: clean");
    end else begin
      $display("tb_wheel_power_limiter_core: errors");
    end
    $finish;
  end

endmodule
